>>> hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// types, constants and the half-step coil table of the stepper sequencer
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned STEPS_PER_REV_DEF = 4096;

  localparam int unsigned ANGLE_W   = 9;
  localparam int unsigned COIL_W    = 4;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned STEPS_W   = 13;

  localparam logic [ANGLE_W-1:0]  MAX_ANGLE   = 9'd360;
  localparam logic [STEPS_W-1:0]  STEPS_MAX   = 13'h1FFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd2;

  // angle * remainder is below 360 * 360, so 17 bits hold it
  localparam int unsigned REM_PROD_W = 17;
  // floor(z / 45) = (z * RECIP_45) >> RECIP_SHIFT, exact for z below 2**14
  localparam int unsigned RECIP_45    = 23302;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned QUOT_W      = 9;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_ROTATE = 2'd2,
    MODE_STOP   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic               direction;
    logic [ANGLE_W-1:0] angle_deg;
  } cmd_t;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              running;
    logic              stepped;
    logic              state_event;
  } rsp_t;

  function automatic logic [COIL_W-1:0] half_step_coils(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] c;
    case (ph)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/shs_ifs.sv
// ----------------------------------------------------------------------------
// shs_cmd_if / shs_rsp_if
// valid/ready channels carrying sequencer events and results
// ----------------------------------------------------------------------------
interface shs_cmd_if;
  logic          valid;
  logic          ready;
  shs_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface shs_rsp_if;
  logic          valid;
  logic          ready;
  shs_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/stepper_half_step_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer
// half-step driver for a four-coil unipolar stepper motor
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one event per transfer: tick, continuous start, rotate by
//   angle or stop. rsp returns exactly one result per event, in order, with
//   the coil levels, the run flag, a stepped flag and a run-state event flag.
//   tick_period_we / tick_period_wdata load the ticks between half steps;
//   write it only while no event is in flight.
//   A cmd transfer loads the input register (constant multiplies of the
//   saturated angle sit in front of it); the result register (reciprocal
//   multiply for the /360 and state update) is loaded from it whenever rsp
//   can take a new result, and rsp valid rises when it is loaded.
//   Throughput is one event per cycle while rsp does not stall.
//   When rsp stalls, the result register holds and the input register can
//   still take one more event, after which cmd.ready drops.
//   Reset (rst, synchronous) clears phase, coils, run state, counters and
//   both stage valids, and sets tick_period to 2.
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer #(
  parameter int unsigned STEPS_PER_REV = shs_pkg::STEPS_PER_REV_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  shs_cmd_if.sink                        cmd,
  shs_rsp_if.source                      rsp,
  input  logic                           tick_period_we,
  input  logic [shs_pkg::PERIOD_W-1:0]   tick_period_wdata
);
  import shs_pkg::*;

  localparam int unsigned SPR_QUOT = STEPS_PER_REV / 360;
  localparam int unsigned SPR_REM  = STEPS_PER_REV % 360;
  localparam int unsigned BASE_W   = $clog2(STEPS_PER_REV + 1);

  // configuration and motor state
  logic [PERIOD_W-1:0] tick_period;
  logic [PHASE_W-1:0]  phase, phase_next;
  logic [COIL_W-1:0]   coil_levels, coil_levels_next;
  logic                run_flag, run_flag_next;
  logic [PERIOD_W-1:0] tick_count, tick_count_next;
  logic [STEPS_W-1:0]  steps_left, steps_left_next;
  logic                dir_ccw, dir_ccw_next;

  // input register
  logic                  s1_valid;
  mode_t                 s1_mode;
  logic                  s1_dir;
  logic [BASE_W-1:0]     s1_base;
  logic [REM_PROD_W-1:0] s1_rem_prod;

  logic advance;
  logic stepped_next, event_next;

  logic [ANGLE_W-1:0] angle_sat;
  logic [31:0]        base_full, rem_full, quot_full, total_full;
  logic [QUOT_W-1:0]  quot;
  logic [STEPS_W-1:0] steps_total;
  logic [PERIOD_W-1:0] tick_inc;

  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign cmd.ready = !s1_valid || advance;

  // stage 1: saturate angle, split angle*SPR/360 into angle*Q + angle*R/360
  always_comb begin
    angle_sat = (cmd.payload.angle_deg > MAX_ANGLE) ? MAX_ANGLE : cmd.payload.angle_deg;
    base_full = 32'(angle_sat) * 32'(SPR_QUOT);
    rem_full  = 32'(angle_sat) * 32'(SPR_REM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_mode     <= cmd.payload.mode;
      s1_dir      <= cmd.payload.direction;
      s1_base     <= base_full[BASE_W-1:0];
      s1_rem_prod <= rem_full[REM_PROD_W-1:0];
    end
  end

  // stage 2: finish the division by 360 and update the motor state
  always_comb begin
    quot_full   = 32'(s1_rem_prod[REM_PROD_W-1:3]) * 32'(RECIP_45);
    quot        = quot_full[RECIP_SHIFT +: QUOT_W];
    total_full  = 32'(s1_base) + 32'(quot);
    steps_total = (total_full > 32'(STEPS_MAX)) ? STEPS_MAX : total_full[STEPS_W-1:0];
    tick_inc    = tick_count + 1'b1;

    phase_next       = phase;
    coil_levels_next = coil_levels;
    run_flag_next    = run_flag;
    tick_count_next  = tick_count;
    steps_left_next  = steps_left;
    dir_ccw_next     = dir_ccw;
    stepped_next     = 1'b0;
    event_next       = 1'b0;

    unique case (s1_mode)
      MODE_TICK: begin
        if (run_flag) begin
          if (tick_inc >= tick_period) begin
            tick_count_next  = '0;
            phase_next       = dir_ccw ? phase - 1'b1 : phase + 1'b1;
            coil_levels_next = half_step_coils(phase_next);
            stepped_next     = 1'b1;
            if (steps_left != '0) begin
              steps_left_next = steps_left - 1'b1;
              // last counted step halts the motor
              if (steps_left_next == '0) begin
                run_flag_next    = 1'b0;
                dir_ccw_next     = 1'b0;
                coil_levels_next = '0;
                event_next       = 1'b1;
              end
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      MODE_START: begin
        dir_ccw_next  = s1_dir;
        run_flag_next = 1'b1;
      end
      MODE_ROTATE: begin
        if (steps_total == '0) begin
          run_flag_next    = 1'b0;
          steps_left_next  = '0;
          dir_ccw_next     = 1'b0;
          coil_levels_next = '0;
        end else begin
          steps_left_next = steps_total;
          dir_ccw_next    = s1_dir;
          run_flag_next   = 1'b1;
        end
        event_next = 1'b1;
      end
      MODE_STOP: begin
        run_flag_next    = 1'b0;
        steps_left_next  = '0;
        dir_ccw_next     = 1'b0;
        coil_levels_next = '0;
        event_next       = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= PERIOD_RST;
      phase       <= '0;
      coil_levels <= '0;
      run_flag    <= 1'b0;
      tick_count  <= '0;
      steps_left  <= '0;
      dir_ccw     <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (tick_period_we) begin
        tick_period <= tick_period_wdata;
      end
      if (advance) begin
        phase       <= phase_next;
        coil_levels <= coil_levels_next;
        run_flag    <= run_flag_next;
        tick_count  <= tick_count_next;
        steps_left  <= steps_left_next;
        dir_ccw     <= dir_ccw_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.payload.coils       <= coil_levels_next;
      rsp.payload.running     <= run_flag_next;
      rsp.payload.stepped     <= stepped_next;
      rsp.payload.state_event <= event_next;
    end
  end

endmodule
